// ----- rtl/i2cseq_pkg.sv -----
// Package with shared types and constants of the I2C transaction sequencer.
package i2cseq_pkg;

    // Depth of the command byte store.
    localparam int CMD_DEPTH = 16;
    localparam int CMD_AW    = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;

    // Item command codes.
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_STATUS = 2'd2;

    // Bus action codes.
    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_START   = 2'd1;
    localparam logic [1:0] ACT_STOP    = 2'd2;
    localparam logic [1:0] ACT_DISABLE = 2'd3;

    // Acknowledge control codes.
    localparam logic [1:0] ACK_KEEP = 2'd0;
    localparam logic [1:0] ACK_ACK  = 2'd1;
    localparam logic [1:0] ACK_NACK = 2'd2;

    // Transaction result codes.
    localparam logic [1:0] RES_OK        = 2'd0;
    localparam logic [1:0] RES_ADDR_NACK = 2'd1;
    localparam logic [1:0] RES_DATA_NACK = 2'd2;
    localparam logic [1:0] RES_UNKNOWN   = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_TARGET_ADDR     = 2'd0;
    localparam logic [1:0] REG_COMMAND_LENGTH  = 2'd1;
    localparam logic [1:0] REG_RESPONSE_LENGTH = 2'd2;

    // Bus controller status codes with the low three bits cleared.
    localparam logic [7:0] ST_START    = 8'h08;
    localparam logic [7:0] ST_RSTART   = 8'h10;
    localparam logic [7:0] ST_AW_ACK   = 8'h18;
    localparam logic [7:0] ST_AW_NACK  = 8'h20;
    localparam logic [7:0] ST_DW_ACK   = 8'h28;
    localparam logic [7:0] ST_DW_NACK  = 8'h30;
    localparam logic [7:0] ST_ARB_LOST = 8'h38;
    localparam logic [7:0] ST_AR_ACK   = 8'h40;
    localparam logic [7:0] ST_AR_NACK  = 8'h48;
    localparam logic [7:0] ST_DR_ACK   = 8'h50;
    localparam logic [7:0] ST_DR_NACK  = 8'h58;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] status_code;
        logic [7:0] data_byte;
        logic [3:0] load_index;
    } item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [1:0] bus_action;
        logic [1:0] ack_control;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic [7:0] rx_index;
        logic       done_res;
        logic [1:0] result_code;
        logic [7:0] bytes_received;
    } result_t;

    typedef struct packed {
        logic [6:0] target_addr;
        logic [4:0] command_length;
        logic [7:0] response_length;
    } cfg_t;

endpackage

// ----- rtl/i2cseq_if.sv -----
// Valid/ready channel interfaces for sequencer items and results.
interface i2cseq_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] status_code;
    logic [7:0] data_byte;
    logic [3:0] load_index;

    modport source (output valid, output cmd, output status_code, output data_byte,
                    output load_index, input ready);
    modport sink (input valid, input cmd, input status_code, input data_byte,
                  input load_index, output ready);
endinterface

interface i2cseq_result_if;
    logic       valid;
    logic       ready;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [1:0] bus_action;
    logic [1:0] ack_control;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic [7:0] rx_index;
    logic       done_res;
    logic [1:0] result_code;
    logic [7:0] bytes_received;

    modport source (output valid, output tx_valid, output tx_byte, output bus_action,
                    output ack_control, output rx_valid, output rx_data,
                    output rx_index, output done_res, output result_code,
                    output bytes_received, input ready);
    modport sink (input valid, input tx_valid, input tx_byte, input bus_action,
                  input ack_control, input rx_valid, input rx_data,
                  input rx_index, input done_res, input result_code,
                  input bytes_received, output ready);
endinterface

// ----- rtl/i2cseq_cmd_store.sv -----
// Generic RAM with one write port and one registered read port.
module i2cseq_cmd_store #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Entries hold no reset value; the user must load them before use, which the store does not enforce.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/i2cseq_core.sv -----
// Transaction state and status decode for one item per cycle while fire is high.
module i2cseq_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  i2cseq_pkg::item_t   item,
    input  i2cseq_pkg::cfg_t    cfg,
    output i2cseq_pkg::result_t res
);

    logic       busy_reg, busy_next;
    logic [7:0] addr_reg, addr_next;
    logic [7:0] count_reg, count_next;
    logic       byp_hit_reg, byp_hit_next;
    logic [7:0] byp_data_reg;

    logic                          store_we;
    logic [i2cseq_pkg::CMD_AW-1:0] store_waddr;
    logic [i2cseq_pkg::CMD_AW-1:0] store_raddr;
    logic [7:0]                    store_rdata;
    logic [7:0]                    cmd_byte;
    logic [8:0]                    eff_len;
    logic [7:0]                    status;
    logic                          report_count;

    i2cseq_cmd_store #(
        .WIDTH (8),
        .DEPTH (i2cseq_pkg::CMD_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (item.data_byte),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    assign store_we = fire && (item.cmd == i2cseq_pkg::CMD_LOAD)
                      && (32'(item.load_index) < i2cseq_pkg::CMD_DEPTH);

    assign store_waddr = i2cseq_pkg::CMD_AW'(item.load_index);

    // The store is read at the counter value the next item sees, ahead of that item.
    assign store_raddr = fire ? i2cseq_pkg::CMD_AW'(count_next)
                              : i2cseq_pkg::CMD_AW'(count_reg);

    // A load into the entry fetched at the same edge is forwarded.
    assign byp_hit_next = store_we && (store_waddr == store_raddr);
    assign cmd_byte     = byp_hit_reg ? byp_data_reg : store_rdata;

    assign eff_len = (32'(cfg.command_length) > i2cseq_pkg::CMD_DEPTH)
                     ? 9'(i2cseq_pkg::CMD_DEPTH) : 9'(cfg.command_length);

    assign status = {item.status_code[7:3], 3'b000};

    always_comb
    begin
        res          = '0;
        busy_next    = busy_reg;
        addr_next    = addr_reg;
        count_next   = count_reg;
        report_count = 1'b0;
        case (item.cmd)
            i2cseq_pkg::CMD_START:
            begin
                if (!busy_reg)
                begin
                    if (cfg.command_length != 5'd0 || cfg.response_length != 8'd0)
                    begin
                        addr_next      = {cfg.target_addr,
                                          cfg.command_length == 5'd0};
                        busy_next      = 1'b1;
                        count_next     = 8'd0;
                        res.bus_action = i2cseq_pkg::ACT_START;
                        report_count   = 1'b1;
                    end
                    else
                    begin
                        // Nothing to send or receive: report done at once.
                        res.done_res = 1'b1;
                    end
                end
            end
            i2cseq_pkg::CMD_STATUS:
            begin
                report_count = 1'b1;
                case (status)
                    i2cseq_pkg::ST_START, i2cseq_pkg::ST_RSTART:
                    begin
                        res.tx_valid = 1'b1;
                        res.tx_byte  = addr_reg;
                    end
                    i2cseq_pkg::ST_AW_ACK, i2cseq_pkg::ST_DW_ACK:
                    begin
                        if ({1'b0, count_reg} < eff_len)
                        begin
                            res.tx_valid = 1'b1;
                            res.tx_byte  = cmd_byte;
                            count_next   = count_reg + 8'd1;
                        end
                        else if (cfg.response_length != 8'd0)
                        begin
                            // Switch to the read phase with a repeated start.
                            addr_next      = {addr_reg[7:1], 1'b1};
                            count_next     = 8'd0;
                            res.bus_action = i2cseq_pkg::ACT_START;
                        end
                        else
                        begin
                            res.bus_action  = i2cseq_pkg::ACT_STOP;
                            busy_next       = 1'b0;
                            res.done_res    = 1'b1;
                            res.result_code = i2cseq_pkg::RES_OK;
                        end
                    end
                    i2cseq_pkg::ST_AW_NACK, i2cseq_pkg::ST_AR_NACK:
                    begin
                        res.bus_action  = i2cseq_pkg::ACT_STOP;
                        busy_next       = 1'b0;
                        res.done_res    = 1'b1;
                        res.result_code = i2cseq_pkg::RES_ADDR_NACK;
                    end
                    i2cseq_pkg::ST_DW_NACK:
                    begin
                        res.bus_action  = i2cseq_pkg::ACT_STOP;
                        busy_next       = 1'b0;
                        res.done_res    = 1'b1;
                        res.result_code = i2cseq_pkg::RES_DATA_NACK;
                    end
                    i2cseq_pkg::ST_ARB_LOST:
                    begin
                        res.bus_action = i2cseq_pkg::ACT_START;
                    end
                    i2cseq_pkg::ST_DR_NACK:
                    begin
                        // Last response byte arrived; close the transaction.
                        res.rx_valid    = 1'b1;
                        res.rx_data     = item.data_byte;
                        res.rx_index    = count_reg;
                        count_next      = count_reg + 8'd1;
                        res.bus_action  = i2cseq_pkg::ACT_STOP;
                        busy_next       = 1'b0;
                        res.done_res    = 1'b1;
                        res.result_code = i2cseq_pkg::RES_OK;
                    end
                    i2cseq_pkg::ST_DR_ACK, i2cseq_pkg::ST_AR_ACK:
                    begin
                        if (status == i2cseq_pkg::ST_DR_ACK)
                        begin
                            res.rx_valid = 1'b1;
                            res.rx_data  = item.data_byte;
                            res.rx_index = count_reg;
                            count_next   = count_reg + 8'd1;
                        end
                        // Acknowledge unless the next byte is the last one.
                        if (({1'b0, count_next} + 9'd1) < {1'b0, cfg.response_length})
                        begin
                            res.ack_control = i2cseq_pkg::ACK_ACK;
                        end
                        else
                        begin
                            res.ack_control = i2cseq_pkg::ACK_NACK;
                        end
                    end
                    default:
                    begin
                        res.bus_action  = i2cseq_pkg::ACT_DISABLE;
                        busy_next       = 1'b0;
                        res.done_res    = 1'b1;
                        res.result_code = i2cseq_pkg::RES_UNKNOWN;
                    end
                endcase
            end
            default:
            begin
                // Loads produce an all-zero result; unused codes are ignored.
            end
        endcase
        if (report_count && addr_next[0])
        begin
            res.bytes_received = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            addr_reg     <= 8'd0;
            count_reg    <= 8'd0;
            byp_hit_reg  <= 1'b0;
            byp_data_reg <= 8'd0;
        end
        else
        begin
            byp_hit_reg  <= byp_hit_next;
            byp_data_reg <= item.data_byte;
            if (fire)
            begin
                busy_reg  <= busy_next;
                addr_reg  <= addr_next;
                count_reg <= count_next;
            end
        end
    end

    // A finished transaction leaves the block idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.done_res |=> !busy_reg)
        else $error("busy still set after transaction end");

    // Every delivered response byte advances the byte counter by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.rx_valid |=> count_reg == $past(count_reg) + 8'd1)
        else $error("byte counter did not advance on received byte");

    // One item never both sends and receives a byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(res.tx_valid && res.rx_valid))
        else $error("transmit and receive in the same item");

    // Bytes received are only reported during the read phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && (res.bytes_received != 8'd0) |=> addr_reg[0])
        else $error("byte count reported outside the read phase");

endmodule

// ----- rtl/i2c_master_transaction_sequencer.sv -----
// Top level of the I2C master write-then-read transaction sequencer.
// The sequencer turns bus controller status events into the next bus step of
// one write-then-read I2C transaction and returns exactly one result item for
// every item it accepts. An accepted item waits in the input register; the
// decode and the update of the transaction state then land in the output
// register. A new item is taken in every cycle, so the sustained rate is
// one item per clock as long as the result side keeps taking results; the
// output register stalls the input register, and the input register stalls
// the item channel, when it does not.
// Command bytes are loaded with load items (one byte per item, positions at or
// beyond the store depth are ignored) before a start item opens the
// transaction; a start item while a transaction runs is ignored and yields an
// all-zero result. Configuration writes go straight to the registers and may
// be issued only while no item is in flight. Command store entries that were
// never loaded read back as arbitrary data, so command_length must not exceed
// the number of loaded bytes.
module i2c_master_transaction_sequencer (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [7:0]    cfg_data,
    i2cseq_item_if.sink   item,
    i2cseq_result_if.source result
);

    i2cseq_pkg::cfg_t    cfg_reg;
    i2cseq_pkg::item_t   in_item_reg;
    i2cseq_pkg::item_t   in_item;
    i2cseq_pkg::result_t out_res_reg;
    i2cseq_pkg::result_t core_res;
    logic                in_valid_reg;
    logic                out_valid_reg;
    logic                advance;

    // The input register hands its item to the core whenever the output
    // register is empty or is being emptied in this cycle.
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;

    assign in_item.cmd         = item.cmd;
    assign in_item.status_code = item.status_code;
    assign in_item.data_byte   = item.data_byte;
    assign in_item.load_index  = item.load_index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                i2cseq_pkg::REG_TARGET_ADDR:     cfg_reg.target_addr     <= cfg_data[6:0];
                i2cseq_pkg::REG_COMMAND_LENGTH:  cfg_reg.command_length  <= cfg_data[4:0];
                i2cseq_pkg::REG_RESPONSE_LENGTH: cfg_reg.response_length <= cfg_data;
                default:
                begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item.ready)
            begin
                in_valid_reg <= item.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_item_reg <= in_item;
        end
        if (advance)
        begin
            out_res_reg <= core_res;
        end
    end

    i2cseq_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (in_item_reg),
        .cfg   (cfg_reg),
        .res   (core_res)
    );

    assign result.valid          = out_valid_reg;
    assign result.tx_valid       = out_res_reg.tx_valid;
    assign result.tx_byte        = out_res_reg.tx_byte;
    assign result.bus_action     = out_res_reg.bus_action;
    assign result.ack_control    = out_res_reg.ack_control;
    assign result.rx_valid       = out_res_reg.rx_valid;
    assign result.rx_data        = out_res_reg.rx_data;
    assign result.rx_index       = out_res_reg.rx_index;
    assign result.done_res       = out_res_reg.done_res;
    assign result.result_code    = out_res_reg.result_code;
    assign result.bytes_received = out_res_reg.bytes_received;

    // An item waiting in the input register is never dropped.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("pending item lost from input register");

    // A result that is not taken stays in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |=> out_valid_reg)
        else $error("pending result lost from output register");

    // The core only runs when the output register can take its result.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> !out_valid_reg || result.ready)
        else $error("core fired into a full output register");

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the I2C master transaction sequencer.
module tb_top;

    // Run sizing. The idle limit counts cycles in which neither channel moves an
    // item. It stays well above the long receiver hold-off, the sender gaps and
    // the configuration pauses.
    localparam int TOTAL_ITEMS     = 1400;
    localparam int IDLE_LIMIT      = 4000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WRAP_EVENTS     = 300;

    // The command field leaves one code unused. The block must ignore it.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // The low three bits of a status byte are not part of the code.
    localparam logic [7:0] ST_MASK    = 8'hF8;
    localparam logic [7:0] ST_NO_INFO = 8'hF8;

    // Pacing patterns of the result receiver.
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_STARVED} rx_pace_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    i2cseq_item_if   item_ch();
    i2cseq_result_if res_ch();

    i2c_master_transaction_sequencer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (res_ch)
    );

    // Shadow copy of the sequencer: its configuration, transaction state and
    // command store. The expected results wait in acceptance order.
    i2cseq_pkg::cfg_t    seq_cfg;
    logic                seq_busy;
    logic [7:0]          seq_addr;
    logic [7:0]          seq_count;
    logic [7:0]          seq_store [i2cseq_pkg::CMD_DEPTH];
    i2cseq_pkg::result_t expected_steps[$];

    int       errors      = 0;
    int       items_sent  = 0;
    int       burst_left  = 0;
    bit       no_gaps     = 1'b0;
    int       idle_cycles = 0;
    int       stall_id    = 0;
    int       stall_taken = 0;
    int       stall_left  = 0;
    int       pace_left   = 0;
    int       pace_step   = 0;
    rx_pace_t pace        = RX_OPEN;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Works out the bus step that one accepted item causes. The shadow state is
    // updated on the way. Loads, ignored starts and the unused command give an
    // all-zero step.
    function automatic i2cseq_pkg::result_t bus_step(i2cseq_pkg::item_t it);
        i2cseq_pkg::result_t r;
        int                  eff_len;
        logic [7:0]          code;
        r = '0;
        eff_len = (seq_cfg.command_length > i2cseq_pkg::CMD_DEPTH)
                  ? i2cseq_pkg::CMD_DEPTH : int'(seq_cfg.command_length);
        code = it.status_code & ST_MASK;
        case (it.cmd)
            i2cseq_pkg::CMD_LOAD:
            begin
                seq_store[it.load_index] = it.data_byte;
                return r;
            end
            i2cseq_pkg::CMD_START:
            begin
                if (seq_busy)
                    return r;
                if (seq_cfg.command_length != 0)
                    seq_addr = {seq_cfg.target_addr, 1'b0};
                else if (seq_cfg.response_length != 0)
                    seq_addr = {seq_cfg.target_addr, 1'b1};
                else
                begin
                    // Nothing to write and nothing to read: done at once.
                    r.done_res = 1'b1;
                    return r;
                end
                seq_busy     = 1'b1;
                seq_count    = 8'd0;
                r.bus_action = i2cseq_pkg::ACT_START;
            end
            i2cseq_pkg::CMD_STATUS:
            begin
                case (code)
                    i2cseq_pkg::ST_START, i2cseq_pkg::ST_RSTART:
                    begin
                        r.tx_valid = 1'b1;
                        r.tx_byte  = seq_addr;
                    end
                    i2cseq_pkg::ST_AW_ACK, i2cseq_pkg::ST_DW_ACK:
                    begin
                        if (int'(seq_count) < eff_len)
                        begin
                            r.tx_valid = 1'b1;
                            r.tx_byte  = seq_store[seq_count[3:0]];
                            seq_count  = seq_count + 8'd1;
                        end
                        else if (seq_cfg.response_length != 0)
                        begin
                            // Turn around for the read with a repeated start.
                            seq_addr     = seq_addr | 8'd1;
                            seq_count    = 8'd0;
                            r.bus_action = i2cseq_pkg::ACT_START;
                        end
                        else
                        begin
                            r.bus_action  = i2cseq_pkg::ACT_STOP;
                            r.done_res    = 1'b1;
                            r.result_code = i2cseq_pkg::RES_OK;
                            seq_busy      = 1'b0;
                        end
                    end
                    i2cseq_pkg::ST_AW_NACK, i2cseq_pkg::ST_AR_NACK:
                    begin
                        r.bus_action  = i2cseq_pkg::ACT_STOP;
                        r.done_res    = 1'b1;
                        r.result_code = i2cseq_pkg::RES_ADDR_NACK;
                        seq_busy      = 1'b0;
                    end
                    i2cseq_pkg::ST_DW_NACK:
                    begin
                        r.bus_action  = i2cseq_pkg::ACT_STOP;
                        r.done_res    = 1'b1;
                        r.result_code = i2cseq_pkg::RES_DATA_NACK;
                        seq_busy      = 1'b0;
                    end
                    i2cseq_pkg::ST_ARB_LOST:
                        r.bus_action = i2cseq_pkg::ACT_START;
                    i2cseq_pkg::ST_DR_NACK:
                    begin
                        r.rx_valid    = 1'b1;
                        r.rx_data     = it.data_byte;
                        r.rx_index    = seq_count;
                        seq_count     = seq_count + 8'd1;
                        r.bus_action  = i2cseq_pkg::ACT_STOP;
                        r.done_res    = 1'b1;
                        r.result_code = i2cseq_pkg::RES_OK;
                        seq_busy      = 1'b0;
                    end
                    i2cseq_pkg::ST_DR_ACK, i2cseq_pkg::ST_AR_ACK:
                    begin
                        if (code == i2cseq_pkg::ST_DR_ACK)
                        begin
                            r.rx_valid = 1'b1;
                            r.rx_data  = it.data_byte;
                            r.rx_index = seq_count;
                            seq_count  = seq_count + 8'd1;
                        end
                        // Every byte is acknowledged except the last one.
                        r.ack_control = (int'(seq_count) + 1 < int'(seq_cfg.response_length))
                                        ? i2cseq_pkg::ACK_ACK : i2cseq_pkg::ACK_NACK;
                    end
                    default:
                    begin
                        r.bus_action  = i2cseq_pkg::ACT_DISABLE;
                        r.done_res    = 1'b1;
                        r.result_code = i2cseq_pkg::RES_UNKNOWN;
                        seq_busy      = 1'b0;
                    end
                endcase
            end
            default:
                return r;
        endcase
        r.bytes_received = seq_addr[0] ? seq_count : 8'd0;
        return r;
    endfunction

    // Result checker. A result counts when valid and ready are both high at a
    // rising edge. It is compared with the oldest expected step.
    always @(posedge clk)
    begin : result_check
        i2cseq_pkg::result_t seen;
        i2cseq_pkg::result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            seen.tx_valid       = res_ch.tx_valid;
            seen.tx_byte        = res_ch.tx_byte;
            seen.bus_action     = res_ch.bus_action;
            seen.ack_control    = res_ch.ack_control;
            seen.rx_valid       = res_ch.rx_valid;
            seen.rx_data        = res_ch.rx_data;
            seen.rx_index       = res_ch.rx_index;
            seen.done_res       = res_ch.done_res;
            seen.result_code    = res_ch.result_code;
            seen.bytes_received = res_ch.bytes_received;
            if (expected_steps.size() == 0)
            begin
                errors++;
                $display("%0t: result with no item outstanding: expected none, got %h",
                         $time, seen);
            end
            else
            begin
                want = expected_steps.pop_front();
                if (want !== seen)
                begin
                    errors++;
                    $display("%0t: result mismatch: expected %h, got %h",
                             $time, want, seen);
                end
            end
        end
    end

    // Watchdog. It counts cycles in which nothing moves on either channel.
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL i2c_master_transaction_sequencer");
            $finish;
        end
    end

    // Result receiver. Its ready follows a pacing pattern that is chosen anew at
    // random. A hold-off request forces ready low for a counted stretch, and the
    // block fills up behind it.
    always @(negedge clk)
    begin
        if (stall_id != stall_taken)
        begin
            stall_left  = HOLD_OFF_CYCLES;
            stall_taken = stall_id;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (pace_left == 0)
            begin
                pace      = rx_pace_t'($urandom_range(0, 3));
                pace_left = $urandom_range(20, 150);
            end
            pace_left--;
            pace_step++;
            case (pace)
                RX_OPEN:     res_ch.ready <= 1'b1;
                RX_COIN:     res_ch.ready <= 1'($urandom_range(0, 1));
                RX_PERIODIC: res_ch.ready <= (pace_step % 4) != 0;
                default:     res_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Offers one item and returns at the edge where the block takes it. The
    // sender works in bursts. Before a new burst it may drop valid for a random
    // gap. Valid stays high between items inside a burst.
    task automatic send_item(i2cseq_pkg::item_t it);
        int gap;
        if (burst_left == 0)
        begin
            if (no_gaps)
                gap = 0;
            else if ($urandom_range(0, 3) == 0)
                gap = $urandom_range(5, 20);
            else
                gap = $urandom_range(0, 3);
            if (gap > 0)
            begin
                @(negedge clk);
                item_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        item_ch.valid       <= 1'b1;
        item_ch.cmd         <= it.cmd;
        item_ch.status_code <= it.status_code;
        item_ch.data_byte   <= it.data_byte;
        item_ch.load_index  <= it.load_index;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        expected_steps.push_back(bus_step(it));
        items_sent++;
    endtask

    task automatic send_status(logic [7:0] code);
        i2cseq_pkg::item_t it;
        it.cmd         = i2cseq_pkg::CMD_STATUS;
        it.status_code = code | 8'($urandom_range(0, 7));
        it.data_byte   = 8'($urandom);
        it.load_index  = 4'($urandom);
        send_item(it);
    endtask

    task automatic send_start();
        i2cseq_pkg::item_t it;
        it.cmd         = i2cseq_pkg::CMD_START;
        it.status_code = 8'($urandom);
        it.data_byte   = 8'($urandom);
        it.load_index  = 4'($urandom);
        send_item(it);
    endtask

    task automatic send_load(logic [3:0] idx, logic [7:0] value);
        i2cseq_pkg::item_t it;
        it.cmd         = i2cseq_pkg::CMD_LOAD;
        it.status_code = 8'($urandom);
        it.data_byte   = value;
        it.load_index  = idx;
        send_item(it);
    endtask

    // One item that fits no transaction: the unused command, a stray status or
    // start, or a load into the store.
    task automatic send_noise();
        i2cseq_pkg::item_t it;
        it.status_code = 8'($urandom);
        it.data_byte   = 8'($urandom);
        it.load_index  = 4'($urandom);
        case ($urandom_range(0, 3))
            0:       it.cmd = CMD_UNUSED;
            1:       it.cmd = i2cseq_pkg::CMD_STATUS;
            2:       it.cmd = i2cseq_pkg::CMD_START;
            default: it.cmd = i2cseq_pkg::CMD_LOAD;
        endcase
        send_item(it);
    endtask

    // Drops valid and waits until every expected step has come back. Then it
    // waits out DRAIN_CYCLES so that nothing is left inside the block.
    task automatic settle();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (expected_steps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(logic [6:0] target, logic [4:0] cmd_len, logic [7:0] resp_len);
        settle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= i2cseq_pkg::REG_TARGET_ADDR;
        cfg_data  <= {1'b0, target};
        @(negedge clk);
        cfg_index <= i2cseq_pkg::REG_COMMAND_LENGTH;
        cfg_data  <= {3'b000, cmd_len};
        @(negedge clk);
        cfg_index <= i2cseq_pkg::REG_RESPONSE_LENGTH;
        cfg_data  <= resp_len;
        @(negedge clk);
        cfg_we <= 1'b0;
        seq_cfg.target_addr     = target;
        seq_cfg.command_length  = cmd_len;
        seq_cfg.response_length = resp_len;
    endtask

    // Plays one write-then-read transaction as the bus controller would report
    // it. The status codes follow the current configuration. A quarter of the
    // sequences break off at a random point with a fault code. A broken
    // sequence then ends with an unknown status, so that the next one starts
    // from idle. Arbitration losses, a second start and loads are mixed in.
    task automatic run_sequence();
        logic [7:0] codes[$];
        logic [7:0] fault;
        int         eff_len;
        int         cut;
        bit         broken;
        eff_len = (seq_cfg.command_length > i2cseq_pkg::CMD_DEPTH)
                  ? i2cseq_pkg::CMD_DEPTH : int'(seq_cfg.command_length);
        if (seq_cfg.command_length == 0 && seq_cfg.response_length == 0)
        begin
            send_start();
            return;
        end
        codes.push_back(i2cseq_pkg::ST_START);
        if (seq_cfg.command_length != 0)
        begin
            codes.push_back(i2cseq_pkg::ST_AW_ACK);
            repeat (eff_len) codes.push_back(i2cseq_pkg::ST_DW_ACK);
            if (seq_cfg.response_length != 0)
                codes.push_back(i2cseq_pkg::ST_RSTART);
        end
        if (seq_cfg.response_length != 0)
        begin
            codes.push_back(i2cseq_pkg::ST_AR_ACK);
            repeat (int'(seq_cfg.response_length) - 1) codes.push_back(i2cseq_pkg::ST_DR_ACK);
            codes.push_back(i2cseq_pkg::ST_DR_NACK);
        end
        broken = ($urandom_range(0, 3) == 0);
        if (broken)
        begin
            case ($urandom_range(0, 5))
                0:       fault = i2cseq_pkg::ST_AW_NACK;
                1:       fault = i2cseq_pkg::ST_AR_NACK;
                2:       fault = i2cseq_pkg::ST_DW_NACK;
                3:       fault = i2cseq_pkg::ST_ARB_LOST;
                4:       fault = ST_NO_INFO;
                default: fault = 8'($urandom);
            endcase
            cut = $urandom_range(0, codes.size() - 1);
            codes[cut] = fault;
            while (codes.size() > cut + 1)
                void'(codes.pop_back());
        end
        send_start();
        if ($urandom_range(0, 7) == 0)
            send_start();
        foreach (codes[k])
        begin
            if ($urandom_range(0, 19) == 0)
                send_load(4'($urandom), 8'($urandom));
            if (k > 0 && $urandom_range(0, 24) == 0)
            begin
                // Lost arbitration: the block asks for a new start, and the
                // controller then reports the start again.
                send_status(i2cseq_pkg::ST_ARB_LOST);
                send_status(i2cseq_pkg::ST_START);
            end
            send_status(codes[k]);
        end
        if (broken)
            send_status(ST_NO_INFO);
    endtask

    // Every store entry is written before any transaction can read one.
    task automatic test_fill_store();
        for (int i = 0; i < i2cseq_pkg::CMD_DEPTH; i++)
        begin
            if (i == 0)
                send_load(4'(i), 8'h00);
            else if (i == i2cseq_pkg::CMD_DEPTH - 1)
                send_load(4'(i), 8'hFF);
            else
                send_load(4'(i), 8'($urandom));
        end
    endtask

    // Idle behavior: a start with nothing to do, status events decoded while
    // idle, and the unused command.
    task automatic test_idle_events();
        i2cseq_pkg::item_t it;
        set_config(7'd0, 5'd0, 8'd0);
        send_start();
        send_status(ST_NO_INFO);
        send_status(i2cseq_pkg::ST_START);
        send_status(i2cseq_pkg::ST_DR_ACK);
        it.cmd         = CMD_UNUSED;
        it.status_code = 8'hFF;
        it.data_byte   = 8'hFF;
        it.load_index  = 4'hF;
        send_item(it);
    endtask

    // A clean write-then-read at the top address. A start is sent while busy.
    task automatic test_write_read();
        set_config(7'd127, 5'd2, 8'd2);
        send_start();
        send_start();
        send_status(i2cseq_pkg::ST_START);
        send_status(i2cseq_pkg::ST_AW_ACK);
        send_status(i2cseq_pkg::ST_DW_ACK);
        send_status(i2cseq_pkg::ST_DW_ACK);
        send_status(i2cseq_pkg::ST_RSTART);
        send_status(i2cseq_pkg::ST_AR_ACK);
        send_status(i2cseq_pkg::ST_DR_ACK);
        send_status(i2cseq_pkg::ST_DR_NACK);
    endtask

    // Lost arbitration followed by an address NACK, then a NACK on a data byte.
    task automatic test_faults();
        set_config(7'd5, 5'd1, 8'd1);
        send_start();
        send_status(i2cseq_pkg::ST_START);
        send_status(i2cseq_pkg::ST_ARB_LOST);
        send_status(i2cseq_pkg::ST_START);
        send_status(i2cseq_pkg::ST_AW_NACK);
        send_start();
        send_status(i2cseq_pkg::ST_START);
        send_status(i2cseq_pkg::ST_AW_ACK);
        send_status(i2cseq_pkg::ST_DW_NACK);
    endtask

    // A command length above the store depth writes the whole store and no more.
    task automatic test_length_clamp();
        set_config(7'd9, 5'd31, 8'd0);
        send_start();
        send_status(i2cseq_pkg::ST_START);
        send_status(i2cseq_pkg::ST_AW_ACK);
        repeat (i2cseq_pkg::CMD_DEPTH) send_status(i2cseq_pkg::ST_DW_ACK);
    endtask

    // A long read that runs past the response length. The received-byte counter
    // wraps past 255, and the acknowledge control follows the wrapped count.
    task automatic test_counter_wrap();
        set_config(7'h55, 5'd0, 8'd255);
        send_start();
        send_status(i2cseq_pkg::ST_START);
        send_status(i2cseq_pkg::ST_AR_ACK);
        repeat (WRAP_EVENTS) send_status(i2cseq_pkg::ST_DR_ACK);
        send_status(i2cseq_pkg::ST_DR_NACK);
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // items back to back. The block must fill up and stall its input.
    task automatic test_backpressure();
        int start_count;
        set_config(7'($urandom), 5'd3, 8'd20);
        no_gaps     = 1'b1;
        stall_id++;
        start_count = items_sent;
        while (items_sent - start_count < 40)
            run_sequence();
        no_gaps = 1'b0;
    endtask

    // Random phases. Each phase sets a new configuration and then plays a few
    // transactions, with noise in between. Most lengths are short, and now and
    // then a phase uses the extremes.
    task automatic test_random();
        int         phase_left;
        logic [4:0] cmd_len;
        logic [7:0] resp_len;
        phase_left = 0;
        while (items_sent < TOTAL_ITEMS)
        begin
            if (phase_left == 0)
            begin
                case ($urandom_range(0, 5))
                    0:       cmd_len = 5'd0;
                    1:       cmd_len = 5'd16;
                    2:       cmd_len = 5'($urandom_range(17, 31));
                    default: cmd_len = 5'($urandom_range(1, 4));
                endcase
                case ($urandom_range(0, 9))
                    0:       resp_len = 8'd0;
                    1:       resp_len = ($urandom_range(0, 24) == 0)
                                        ? 8'd255 : 8'($urandom_range(7, 20));
                    default: resp_len = 8'($urandom_range(1, 6));
                endcase
                set_config(7'($urandom), cmd_len, resp_len);
                no_gaps    = ($urandom_range(0, 4) == 0);
                phase_left = $urandom_range(3, 8);
            end
            if ($urandom_range(0, 5) == 0)
                send_noise();
            run_sequence();
            phase_left--;
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = i2cseq_pkg::REG_TARGET_ADDR;
        cfg_data            = 8'd0;
        item_ch.valid       = 1'b0;
        item_ch.cmd         = i2cseq_pkg::CMD_LOAD;
        item_ch.status_code = 8'd0;
        item_ch.data_byte   = 8'd0;
        item_ch.load_index  = 4'd0;
        seq_cfg             = '0;
        seq_busy            = 1'b0;
        seq_addr            = 8'd0;
        seq_count           = 8'd0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_fill_store();
        test_idle_events();
        test_write_read();
        test_faults();
        test_length_clamp();
        test_counter_wrap();
        test_backpressure();
        test_random();

        settle();
        if (errors == 0)
            $display("PASS i2c_master_transaction_sequencer");
        else
            $display("FAIL i2c_master_transaction_sequencer");
        $finish;
    end

endmodule
